>>> src/lsor_pkg.sv
// lsor_pkg: shared constants, codes and control types for the sor sweep block
// used by lsor_ctrl, lsor_dp and laplace_sor_sweep_top; no dependencies
package lsor_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int CELL_W   = 32;
  localparam int ERR_W    = 47;
  localparam int W_W      = 15;
  localparam int DIM_W    = 7;
  localparam int POS_W    = 6;
  localparam int SUM_W    = 34;
  localparam int D_W      = 36;
  localparam int P_W      = 52;
  localparam int CFG_IDX_W = 2;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;
  localparam logic [W_W-1:0]   RELAX_RESET = W_W'(16384);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELAX = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_ROWS  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_SW_START,
    ST_SW_W,
    ST_SW_N,
    ST_SW_S,
    ST_SW_E,
    ST_SW_C,
    ST_SW_LAT,
    ST_SW_SUM,
    ST_SW_MUL,
    ST_SW_SAT,
    ST_SW_WB,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    AS_OP,
    AS_N,
    AS_S,
    AS_E,
    AS_W,
    AS_C
  } addr_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_N,
    CAP_S,
    CAP_E,
    CAP_W,
    CAP_C,
    CAP_RD
  } cap_t;

  typedef struct packed {
    logic      latch_in;
    logic      wr_en;
    addr_sel_t addr_sel;
    cap_t      cap;
    logic      cnt_init;
    logic      col_next;
    logic      row_next;
    logic      sum_en;
    logic      mul_en;
    logic      sat_en;
    logic      wb_en;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic small_grid;
    logic last_col;
    logic last_row;
    logic out_free;
  } stat_t;

endpackage

>>> src/lsor_ram.sv
// lsor_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lsor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lsor_ctrl.sv
// lsor_ctrl: sequencer for write, read and sweep transactions
// depends on lsor_pkg
module lsor_ctrl import lsor_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  opcode_t in_op,
  output logic    in_ready,
  input  stat_t   stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (in_op)
            OP_WRITE: state_next = ST_WR;
            OP_SWEEP: state_next = ST_SW_START;
            OP_READ:  state_next = ST_RD_ADDR;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_WR: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_DONE;
      end
      ST_RD_ADDR: begin
        cmd.addr_sel = AS_OP;
        cmd.cap      = CAP_RD;
        state_next   = ST_RD_DATA;
      end
      ST_RD_DATA: state_next = ST_DONE;
      ST_SW_START: begin
        cmd.cnt_init = 1'b1;
        state_next   = stat.small_grid ? ST_DONE : ST_SW_W;
      end
      ST_SW_W: begin
        cmd.addr_sel = AS_W;
        cmd.cap      = CAP_W;
        state_next   = ST_SW_N;
      end
      ST_SW_N: begin
        cmd.addr_sel = AS_N;
        cmd.cap      = CAP_N;
        state_next   = ST_SW_S;
      end
      ST_SW_S: begin
        cmd.addr_sel = AS_S;
        cmd.cap      = CAP_S;
        state_next   = ST_SW_E;
      end
      ST_SW_E: begin
        cmd.addr_sel = AS_E;
        cmd.cap      = CAP_E;
        state_next   = ST_SW_C;
      end
      ST_SW_C: begin
        cmd.addr_sel = AS_C;
        cmd.cap      = CAP_C;
        state_next   = ST_SW_LAT;
      end
      ST_SW_LAT: state_next = ST_SW_SUM;
      ST_SW_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_SW_MUL;
      end
      ST_SW_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SW_SAT;
      end
      ST_SW_SAT: begin
        cmd.sat_en = 1'b1;
        state_next = ST_SW_WB;
      end
      ST_SW_WB: begin
        cmd.wb_en = 1'b1;
        if (stat.last_col) begin
          if (stat.last_row) begin
            state_next = ST_DONE;
          end else begin
            cmd.row_next = 1'b1;
            state_next   = ST_SW_W;
          end
        end else begin
          cmd.col_next = 1'b1;
          state_next   = ST_SW_N;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/lsor_dp.sv
// lsor_dp: grid memory, sweep counters, sor arithmetic and result register
// depends on lsor_pkg and lsor_ram
module lsor_dp import lsor_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  opcode_t                in_op,
  input  logic [POS_W-1:0]       in_row,
  input  logic [POS_W-1:0]       in_col,
  input  logic [CELL_W-1:0]      in_value,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [W_W-1:0]         cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CELL_W+ERR_W-1:0] out_data
);

  logic [W_W-1:0]    relax;
  logic [DIM_W-1:0]  cols_cfg, rows_cfg, nc, nr;
  opcode_t           op_q;
  logic [POS_W-1:0]  row_q, col_q;
  logic [CELL_W-1:0] val_q;
  logic              inside_q;
  logic [DIM_W-1:0]  row_cnt, col_cnt;
  cap_t              cap_q;
  logic signed [CELL_W-1:0] n_val, s_val, e_val, w_val, c_val;
  logic [CELL_W-1:0] rd_val;
  logic signed [D_W-1:0]    d_q;
  logic signed [P_W-1:0]    p_q;
  logic signed [CELL_W-1:0] nv_q;
  logic [ERR_W-1:0]  err;
  logic [ADDR_W-1:0] addr_op, addr_c, addr_n, addr_s, addr_e, addr_w, raddr, waddr;
  logic [CELL_W-1:0] ram_q, wdata;
  logic              ram_we;
  logic signed [SUM_W-1:0]  nb_sum;
  logic signed [P_W-1:0]    p_round;
  logic signed [CELL_W+4:0] nv_wide;
  logic signed [CELL_W:0]   ch;
  logic [CELL_W:0]          mag;
  logic [ERR_W:0]           err_acc;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      relax    <= RELAX_RESET;
      cols_cfg <= DIM_W'(MAX_COLS);
      rows_cfg <= DIM_W'(MAX_ROWS);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RELAX: relax    <= cfg_data;
        CFG_COLS:  cols_cfg <= cfg_data[DIM_W-1:0];
        CFG_ROWS:  rows_cfg <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign nc = (int'(cols_cfg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_cfg;
  assign nr = (int'(rows_cfg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_cfg;

  assign stat.small_grid = (nc < DIM_W'(3)) || (nr < DIM_W'(3));
  assign stat.last_col   = (col_cnt == nc - DIM_W'(2));
  assign stat.last_row   = (row_cnt == nr - DIM_W'(2));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q     <= in_op;
      row_q    <= in_row;
      col_q    <= in_col;
      val_q    <= in_value;
      inside_q <= (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
    end
  end

  // raster counters over the interior cells
  always_ff @(posedge clk) begin
    if (cmd.cnt_init) begin
      row_cnt <= DIM_W'(1);
      col_cnt <= DIM_W'(1);
    end else if (cmd.row_next) begin
      row_cnt <= row_cnt + DIM_W'(1);
      col_cnt <= DIM_W'(1);
    end else if (cmd.col_next) begin
      col_cnt <= col_cnt + DIM_W'(1);
    end
  end

  assign addr_op = cell_addr({1'b0, row_q}, {1'b0, col_q});
  assign addr_c  = cell_addr(row_cnt, col_cnt);
  assign addr_n  = cell_addr(row_cnt - DIM_W'(1), col_cnt);
  assign addr_s  = cell_addr(row_cnt + DIM_W'(1), col_cnt);
  assign addr_e  = cell_addr(row_cnt, col_cnt + DIM_W'(1));
  assign addr_w  = cell_addr(row_cnt, col_cnt - DIM_W'(1));

  always_comb begin
    unique case (cmd.addr_sel)
      AS_OP:   raddr = addr_op;
      AS_N:    raddr = addr_n;
      AS_S:    raddr = addr_s;
      AS_E:    raddr = addr_e;
      AS_W:    raddr = addr_w;
      AS_C:    raddr = addr_c;
      default: raddr = addr_op;
    endcase
  end

  assign ram_we = (cmd.wr_en && inside_q) || cmd.wb_en;
  assign waddr  = cmd.wb_en ? addr_c : addr_op;
  assign wdata  = cmd.wb_en ? nv_q : val_q;

  lsor_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // read data lands in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_q <= CAP_NONE;
    end else begin
      cap_q <= cmd.cap;
    end
  end

  always_ff @(posedge clk) begin
    case (cap_q)
      CAP_N:  n_val  <= ram_q;
      CAP_S:  s_val  <= ram_q;
      CAP_E:  e_val  <= ram_q;
      CAP_W:  w_val  <= ram_q;
      CAP_C:  c_val  <= ram_q;
      CAP_RD: rd_val <= ram_q;
      default: ;
    endcase
    if (cmd.wb_en) begin
      w_val <= nv_q;
    end
  end

  assign nb_sum = SUM_W'(n_val) + SUM_W'(s_val) + SUM_W'(e_val) + SUM_W'(w_val);

  // rounding bias of one half lsb before the floor shift
  assign p_round = p_q + P_W'(32768);
  assign nv_wide = (CELL_W+5)'(c_val) + (CELL_W+5)'($signed(p_round[P_W-1:16]));
  assign ch      = (CELL_W+1)'(nv_q) - (CELL_W+1)'(c_val);
  assign mag     = ch[CELL_W] ? (CELL_W+1)'(-ch) : (CELL_W+1)'(ch);
  assign err_acc = {1'b0, err} + (ERR_W+1)'(mag);

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      d_q <= D_W'(nb_sum) - (D_W'(c_val) <<< 2);
    end
    if (cmd.mul_en) begin
      p_q <= P_W'($signed({1'b0, relax})) * P_W'(d_q);
    end
    if (cmd.sat_en) begin
      if (nv_wide > (CELL_W+5)'(32'sh7FFF_FFFF)) begin
        nv_q <= 32'sh7FFF_FFFF;
      end else if (nv_wide < -(CELL_W+5)'(64'sh8000_0000)) begin
        nv_q <= 32'sh8000_0000;
      end else begin
        nv_q <= nv_wide[CELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      err <= '0;
    end else if (cmd.wb_en) begin
      err <= (err_acc > {1'b0, ERR_MAX}) ? ERR_MAX : err_acc[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data[CELL_W-1:0] <= (op_q == OP_READ && inside_q) ? rd_val : '0;
      out_data[CELL_W+ERR_W-1:CELL_W] <= (op_q == OP_SWEEP) ? err : '0;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an unread result");

  a_wb_interior: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_en |-> (col_cnt >= DIM_W'(1) && col_cnt <= nc - DIM_W'(2)
                   && row_cnt >= DIM_W'(1) && row_cnt <= nr - DIM_W'(2)))
    else $error("sweep write outside the interior");

  a_err_monotonic: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_en && !cmd.latch_in |=> err >= $past(err))
    else $error("sweep error sum decreased");

  a_no_double_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wb_en && cmd.wr_en))
    else $error("host write and sweep write in one cycle");

endmodule

>>> src/laplace_sor_sweep_top.sv
// Gauss-Seidel SOR relaxation of a grid of Q16.16 potentials, 5-point stencil.
// Input channel s_axis: tuser carries the opcode (0 write, 1 sweep, 2 read,
// 3 no-op); tdata carries row, col and the value to write. Every transaction
// returns exactly one result on m_axis: the cell on a read, the saturating
// sum of absolute changes on a sweep, zeros otherwise.
// A sweep over R rows and C columns updates the interior cells in raster
// order, none when R or C is below 3: each interior cell needs reads of the
// single read port of the grid ram (west only at a row start) and four
// arithmetic steps (sum, multiply, saturate, write-back).
// One transaction is worked on at a time; s_axis_tready is high while idle,
// and the next transaction is taken while a result still waits in the
// output register. When the receiver stalls, the result holds and the block
// waits before loading the following one.
// Reset (rst, synchronous) returns the sequencer to idle, drops a pending
// result and restores relax_factor to 1.0 and the grid size to 64 x 64; the
// grid contents are not cleared and must be written before use.
// Configuration via cfg_we/cfg_index/cfg_data; the user must write it only while idle, the block does not enforce this.
// Depends on lsor_pkg, lsor_ctrl, lsor_dp and lsor_ram.
module laplace_sor_sweep_top import lsor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // row[5:0], col[11:6], cell_value[43:12], zero pad
  input  logic [1:0]           s_axis_tuser,  // opcode[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [79:0]          m_axis_tdata,  // read_value[31:0], sweep_error[78:32], zero pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W_W-1:0]       cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic [CELL_W+ERR_W-1:0] out_data;

  lsor_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_op   (opcode_t'(s_axis_tuser)),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lsor_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_op    (opcode_t'(s_axis_tuser)),
    .in_row   (s_axis_tdata[5:0]),
    .in_col   (s_axis_tdata[11:6]),
    .in_value (s_axis_tdata[43:12]),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data};

endmodule

>>> verif/tb_laplace_sor_sweep_top.sv
// testbench for laplace_sor_sweep_top: loads a corner of the grid, then runs directed and
// random writes, reads and sweeps against an in-bench predictor of the sor update
// depends on lsor_pkg and the rtl under src
`timescale 1ns / 100ps

module tb_laplace_sor_sweep_top;
  import lsor_pkg::*;

  localparam int NO_ACCEPT_LIMIT = 200000;
  // side of the loaded corner; sweeps and random reads stay inside it
  localparam int LOAD_N = 6;

  typedef struct {
    logic [31:0] read_value;
    logic [46:0] sweep_error;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;  // row[5:0], col[11:6], cell_value[43:12], zero pad
  logic [1:0]           s_axis_tuser = '0;  // opcode[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;       // read_value[31:0], sweep_error[78:32], zero pad
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [W_W-1:0]       cfg_data = '0;

  // predictor state
  int          grid_cells [DEPTH];
  int          relax_w;
  int          ncols;
  int          nrows;
  result_t     pending_results [$];
  bit          idle_on = 1'b1;
  bit          failed = 1'b0;
  int          quiet_cycles = 0;
  int          ready_gap = 0;

  laplace_sor_sweep_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [46:0] predict_sweep_error();
    longint err;
    longint old_v, nbr_sum, diff, prod, new_v, chg;
    int nc, nr, at;
    nc = (ncols > MAX_COLS) ? MAX_COLS : ncols;
    nr = (nrows > MAX_ROWS) ? MAX_ROWS : nrows;
    err = 0;
    if (nc < 3 || nr < 3) return '0;
    for (int r = 1; r + 1 < nr; r++) begin
      for (int c = 1; c + 1 < nc; c++) begin
        at = r * MAX_COLS + c;
        old_v = grid_cells[at];
        nbr_sum = longint'(grid_cells[at - MAX_COLS]) + longint'(grid_cells[at + MAX_COLS])
                + longint'(grid_cells[at + 1]) + longint'(grid_cells[at - 1]);
        diff = nbr_sum - 4 * old_v;
        prod = longint'(relax_w) * diff;
        new_v = old_v + ((prod + 32768) >>> 16);
        if (new_v > 64'sd2147483647) new_v = 64'sd2147483647;
        if (new_v < -64'sd2147483648) new_v = -64'sd2147483648;
        chg = new_v - old_v;
        if (chg < 0) chg = -chg;
        grid_cells[at] = int'(new_v);
        err += chg;
        if (err > 64'h7FFF_FFFF_FFFF) err = 64'h7FFF_FFFF_FFFF;
      end
    end
    return err[46:0];
  endfunction

  task automatic send_item(opcode_t op, int row, int col, logic [31:0] val);
    result_t exp_res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, val, 6'(col), 6'(row)};
    do @(posedge clk); while (!s_axis_tready);
    exp_res.read_value  = '0;
    exp_res.sweep_error = '0;
    case (op)
      OP_WRITE: grid_cells[row * MAX_COLS + col] = val;
      OP_SWEEP: exp_res.sweep_error = predict_sweep_error();
      OP_READ:  exp_res.read_value = grid_cells[row * MAX_COLS + col];
      default: ;
    endcase
    pending_results.push_back(exp_res);
  endtask

  task automatic drain();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // only called after drain, so the block is idle
  task automatic write_reg(cfg_idx_t idx, logic [W_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RELAX: relax_w = val;
      CFG_COLS:  ncols = val[6:0];
      CFG_ROWS:  nrows = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int cols, int rows);
    write_reg(CFG_COLS, W_W'(cols));
    write_reg(CFG_ROWS, W_W'(rows));
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic test_load_grid();
    for (int r = 0; r < LOAD_N; r++)
      for (int c = 0; c < LOAD_N; c++)
        send_item(OP_WRITE, r, c, rand_value());
    drain();
  endtask

  task automatic test_directed();
    send_item(OP_WRITE, 0, 0, 32'h8000_0000);
    send_item(OP_WRITE, 63, 63, 32'h7FFF_FFFF);
    send_item(OP_WRITE, 0, 63, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 63, 0, 32'h0000_0000);
    send_item(OP_READ, 0, 0, 32'h0);
    send_item(OP_READ, 63, 63, 32'hFFFF_FFFF);
    send_item(OP_READ, 0, 63, 32'h0);
    send_item(OP_READ, 63, 0, 32'h0);
    send_item(OP_NOP, 5, 5, 32'h1234_5678);
    send_item(OP_READ, 5, 5, 32'h0);
    drain();
    set_grid(3, 3);
    send_item(OP_SWEEP, 0, 0, 0);
    send_item(OP_READ, 1, 1, 0);
    drain();
    // undersized grids leave nothing to update
    set_grid(2, 5);
    send_item(OP_SWEEP, 0, 0, 0);
    drain();
    set_grid(5, 0);
    send_item(OP_SWEEP, 0, 0, 0);
    drain();
    // a write to the unused register index changes nothing
    write_reg(CFG_NONE, 15'h7FFF);
    set_grid(4, 4);
    send_item(OP_SWEEP, 0, 0, 0);
    drain();
  endtask

  task automatic test_relax_extremes();
    write_reg(CFG_RELAX, 15'd0);
    set_grid(5, 4);
    send_item(OP_SWEEP, 0, 0, 0);
    send_item(OP_READ, 1, 1, 0);
    drain();
    write_reg(CFG_RELAX, 15'h7FFF);
    send_item(OP_SWEEP, 0, 0, 0);
    send_item(OP_SWEEP, 0, 0, 0);
    send_item(OP_READ, 2, 3, 0);
    drain();
  endtask

  task automatic test_region_sweep();
    // upper data bits of a dimension register are ignored
    write_reg(CFG_RELAX, 15'd16384);
    write_reg(CFG_COLS, 15'h7F80 | 15'(LOAD_N));
    write_reg(CFG_ROWS, 15'(LOAD_N));
    send_item(OP_SWEEP, 0, 0, 0);
    send_item(OP_READ, LOAD_N - 2, LOAD_N - 2, 0);
    drain();
  endtask

  task automatic test_random_traffic(int n_items);
    int op_pick, r, c;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        drain();
        write_reg(CFG_RELAX, $urandom_range(0, 1) ? 15'($urandom()) : 15'($urandom_range(8192, 24576)));
        set_grid($urandom_range(0, LOAD_N), $urandom_range(0, LOAD_N));
      end
      op_pick = $urandom_range(0, 9);
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      if (op_pick < 4)      send_item(OP_WRITE, r, c, rand_value());
      else if (op_pick < 6) send_item(OP_SWEEP, r, c, $urandom());
      else if (op_pick < 9) send_item(OP_READ, r % LOAD_N, c % LOAD_N, $urandom());
      else                  send_item(OP_NOP, r, c, $urandom());
    end
    drain();
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (ready_gap > 0) begin
      ready_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_gap = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== exp_res.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   exp_res.read_value, m_axis_tdata[31:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[78:32] !== exp_res.sweep_error) begin
          $display("%0t: sweep_error expected %h actual %h", $time,
                   exp_res.sweep_error, m_axis_tdata[78:32]);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    relax_w = 16384;
    ncols   = 64;
    nrows   = 64;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_grid();
    test_directed();
    test_relax_extremes();
    test_region_sweep();
    test_random_traffic(60);
    idle_on = 1'b0;
    test_random_traffic(20);
    if (!failed && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
